FILE: src/stdf_pkg.sv
package stdf_pkg;

    localparam logic [31:0] MAX_RECORD_LEN_DEF = 32'd67108864;

    localparam logic [31:0] MARKER_TYPE  = 32'h5858_5858;
    localparam logic [26:0] HEADER_BYTES = 27'd6;
    localparam logic [26:0] EXT_BYTES    = 27'd4;
    localparam logic [15:0] EXT_SIZE     = 16'd4;
    localparam logic [31:0] SIZE_MAX     = 32'h07FF_FFFF;

    localparam logic [2:0] HDR_LAST_IDX = 3'd5;
    localparam logic [2:0] EXT_LAST_IDX = 3'd3;
    localparam logic [2:0] SIZE_LO_IDX  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_EXT,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_DATA,
        KIND_BAD_EXT,
        KIND_OVERRUN
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] sub_type;
        logic [26:0] sub_size;
        logic [25:0] byte_offset;
        logic [7:0]  out_byte;
        logic        last_of_sub;
    } t_result;

endpackage

FILE: src/stdf_skid.sv
module stdf_skid
    import stdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    // Output register plus one spare entry, so the producer can push one
    // more result after the consumer stalls.
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_out_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: src/subrecord_tlv_deframer.sv
// A result is registered in the output register, or in its spare entry while
// the output is stalled, once the word that causes it is accepted. The block
// takes one payload word per cycle while o_in_ready is high, which drops only
// when the spare entry is full. A two-entry output buffer lets one more word
// in after the output stalls. Reset is synchronous and active low; it returns
// the parser to idle and empties the output buffer, with no clearing pass.
module subrecord_tlv_deframer
    import stdf_pkg::*;
#(
    parameter logic [31:0] MAX_RECORD_LEN = MAX_RECORD_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_record_start,
    input  logic [26:0] i_record_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_sub_type,
    output logic [26:0] o_sub_size,
    output logic [25:0] o_byte_offset,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_sub
);

    // Parser state. The header and the extended-size payload are gathered
    // one byte lane at a time.
    t_phase      r_phase,          n_phase;
    logic [2:0]  r_field_count,    n_field_count;
    logic [31:0] r_type_word,      n_type_word;
    logic [15:0] r_short_length,   n_short_length;
    logic [31:0] r_pending_long,   n_pending_long;
    logic [26:0] r_record_left,    n_record_left;
    logic [26:0] r_data_left,      n_data_left;
    logic [25:0] r_data_position,  n_data_position;
    logic [26:0] r_current_length, n_current_length;

    logic        w_accept;
    logic        w_skid_full;
    logic        w_res_valid;
    t_result     w_res;
    t_result     w_out;
    logic [26:0] w_start_len;
    logic [31:0] w_sub;

    assign o_in_ready = ~w_skid_full;
    assign w_accept   = i_in_valid & o_in_ready;

    // Record lengths above the configured maximum are clamped to it.
    always_comb begin
        if ({5'b0, i_record_bytes} > MAX_RECORD_LEN) begin
            w_start_len = MAX_RECORD_LEN[26:0];
        end else begin
            w_start_len = i_record_bytes;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_field_count    = r_field_count;
        n_type_word      = r_type_word;
        n_short_length   = r_short_length;
        n_pending_long   = r_pending_long;
        n_record_left    = r_record_left;
        n_data_left      = r_data_left;
        n_data_position  = r_data_position;
        n_current_length = r_current_length;
        w_res_valid      = 1'b0;
        w_res            = '0;
        w_sub            = '0;

        if (w_accept) begin
            // A record start takes effect on this very word, even mid-record.
            if (i_record_start) begin
                n_record_left  = w_start_len;
                n_pending_long = '0;
                n_field_count  = '0;
                n_phase        = PH_HEADER;
            end

            if (n_phase == PH_IDLE || n_record_left == '0) begin
                n_phase = PH_IDLE;
            end else begin
                unique case (n_phase)
                    PH_HEADER: begin
                        if (n_field_count == '0 && n_record_left < HEADER_BYTES) begin
                            // Too few bytes left for a header: drop the tail quietly.
                            n_phase = PH_IDLE;
                        end else begin
                            if (n_field_count == '0) begin
                                n_type_word    = '0;
                                n_short_length = '0;
                            end
                            n_record_left = n_record_left - 27'd1;
                            if (n_field_count < SIZE_LO_IDX) begin
                                n_type_word[{n_field_count[1:0], 3'b000} +: 8] = i_data_byte;
                            end else if (n_field_count == SIZE_LO_IDX) begin
                                n_short_length = {8'b0, i_data_byte};
                            end else begin
                                n_short_length[15:8] = i_data_byte;
                            end

                            if (n_field_count < HDR_LAST_IDX) begin
                                n_field_count = n_field_count + 3'd1;
                            end else begin
                                n_field_count = '0;
                                w_res.sub_type = n_type_word;
                                if (n_type_word == MARKER_TYPE) begin
                                    if (n_short_length != EXT_SIZE
                                        || n_record_left < EXT_BYTES) begin
                                        n_phase        = PH_IDLE;
                                        w_res_valid    = 1'b1;
                                        w_res.kind     = KIND_BAD_EXT;
                                        w_res.sub_size = {11'b0, n_short_length};
                                    end else begin
                                        n_pending_long = '0;
                                        n_phase        = PH_EXT;
                                    end
                                end else begin
                                    // A nonzero extended size replaces the short one.
                                    if (n_pending_long != '0) begin
                                        w_sub = n_pending_long;
                                    end else begin
                                        w_sub = {16'b0, n_short_length};
                                    end
                                    n_pending_long = '0;
                                    w_res_valid    = 1'b1;
                                    if (w_sub > {5'b0, n_record_left}) begin
                                        n_phase    = PH_IDLE;
                                        w_res.kind = KIND_OVERRUN;
                                        if (w_sub > SIZE_MAX) begin
                                            w_res.sub_size = SIZE_MAX[26:0];
                                        end else begin
                                            w_res.sub_size = w_sub[26:0];
                                        end
                                    end else begin
                                        n_current_length = w_sub[26:0];
                                        n_data_left      = w_sub[26:0];
                                        n_data_position  = '0;
                                        n_phase = (w_sub == '0) ? PH_HEADER : PH_DATA;
                                        w_res.kind       = KIND_HEADER;
                                        w_res.sub_size   = w_sub[26:0];
                                    end
                                end
                            end
                        end
                    end
                    PH_EXT: begin
                        n_record_left = n_record_left - 27'd1;
                        n_pending_long[{n_field_count[1:0], 3'b000} +: 8] = i_data_byte;
                        if (n_field_count < EXT_LAST_IDX) begin
                            n_field_count = n_field_count + 3'd1;
                        end else begin
                            n_field_count = '0;
                            n_phase       = PH_HEADER;
                        end
                    end
                    PH_DATA: begin
                        n_record_left     = n_record_left - 27'd1;
                        w_res_valid       = 1'b1;
                        w_res.kind        = KIND_DATA;
                        w_res.sub_type    = r_type_word;
                        w_res.sub_size    = r_current_length;
                        w_res.byte_offset = r_data_position;
                        w_res.out_byte    = i_data_byte;
                        w_res.last_of_sub = (r_data_left == 27'd1);
                        n_data_position   = r_data_position + 26'd1;
                        if (r_data_left != '0) begin
                            n_data_left = r_data_left - 27'd1;
                        end
                        if (n_data_left == '0) begin
                            n_field_count = '0;
                            n_phase       = PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_field_count    <= '0;
            r_type_word      <= '0;
            r_short_length   <= '0;
            r_pending_long   <= '0;
            r_record_left    <= '0;
            r_data_left      <= '0;
            r_data_position  <= '0;
            r_current_length <= '0;
        end else begin
            r_phase          <= n_phase;
            r_field_count    <= n_field_count;
            r_type_word      <= n_type_word;
            r_short_length   <= n_short_length;
            r_pending_long   <= n_pending_long;
            r_record_left    <= n_record_left;
            r_data_left      <= n_data_left;
            r_data_position  <= n_data_position;
            r_current_length <= n_current_length;
        end
    end

    // Results go through the output register and its spare entry.
    stdf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_skid_full),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_ready (i_out_ready)
    );

    assign o_kind        = w_out.kind;
    assign o_sub_type    = w_out.sub_type;
    assign o_sub_size    = w_out.sub_size;
    assign o_byte_offset = w_out.byte_offset;
    assign o_out_byte    = w_out.out_byte;
    assign o_last_of_sub = w_out.last_of_sub;

endmodule

FILE: verif/subrecord_tlv_deframer_tb.sv
`timescale 1ns / 1ps

module subrecord_tlv_deframer_tb
    import stdf_pkg::*;
();

    // A quiet stretch is at most one full input gap plus one full output stall
    // plus the block's own latency, so WATCHDOG_LIMIT is far past
    // anything a correct block can produce.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_WORDS   = 320;
    localparam int GAP_MAX        = 17;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_record_start;
    logic [26:0] i_record_bytes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [31:0] o_sub_type;
    logic [26:0] o_sub_size;
    logic [25:0] o_byte_offset;
    logic [7:0]  o_out_byte;
    logic        o_last_of_sub;

    subrecord_tlv_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_record_start (i_record_start),
        .i_record_bytes (i_record_bytes),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_sub_type     (o_sub_type),
        .o_sub_size     (o_sub_size),
        .o_byte_offset  (o_byte_offset),
        .o_out_byte     (o_out_byte),
        .o_last_of_sub  (o_last_of_sub)
    );

    // Parser state of the predictor. It mirrors what the block must hold:
    // where we are in a subrecord, the header being assembled, a pending
    // extended size, and what is left of the record and of the data.
    t_phase      prs_phase = PH_IDLE;
    logic [2:0]  hdr_idx   = '0;
    logic [31:0] type_acc  = '0;
    logic [15:0] short_size = '0;
    logic [31:0] long_size = '0;
    logic [26:0] rec_left  = '0;
    logic [26:0] sub_left  = '0;
    logic [25:0] sub_pos   = '0;
    logic [26:0] sub_len   = '0;

    // Results the block still owes us, oldest first.
    t_result deframed_q[$];

    // Payload of the record being built by the stimulus tasks.
    logic [7:0] rec_buf[$];

    int in_gap_max     = 0;
    int out_gap_max    = 0;
    int words_sent     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Works out the result, if any, that one accepted word causes, and
    // advances the predictor's parser state. Returns 1 when a result is due.
    function automatic bit deframe_byte(input logic [7:0] b, input logic st,
                                        input logic [26:0] len, output t_result r);
        logic [31:0] sub;
        r   = '0;
        sub = '0;

        // A record start always wins, even in the middle of another record.
        // Lengths beyond the largest record are clamped to it.
        if (st) begin
            if ({5'd0, len} > MAX_RECORD_LEN_DEF) begin
                rec_left = MAX_RECORD_LEN_DEF[26:0];
            end else begin
                rec_left = len;
            end
            long_size = '0;
            hdr_idx   = '0;
            prs_phase = PH_HEADER;
        end

        // Words outside a record, or of an empty one, are simply dropped.
        if (prs_phase == PH_IDLE || rec_left == '0) begin
            prs_phase = PH_IDLE;
            return 1'b0;
        end

        if (prs_phase == PH_HEADER) begin
            if (hdr_idx == '0) begin
                // Too little left for a whole header: the tail is ignored.
                if (rec_left < HEADER_BYTES) begin
                    prs_phase = PH_IDLE;
                    return 1'b0;
                end
                type_acc   = '0;
                short_size = '0;
            end
            rec_left = rec_left - 27'd1;
            if (hdr_idx < SIZE_LO_IDX) begin
                type_acc[8*hdr_idx +: 8] = b;
            end else if (hdr_idx == SIZE_LO_IDX) begin
                short_size = {8'd0, b};
            end else begin
                short_size[15:8] = b;
            end
            if (hdr_idx < HDR_LAST_IDX) begin
                hdr_idx = hdr_idx + 3'd1;
                return 1'b0;
            end
            hdr_idx    = '0;
            r.sub_type = type_acc;

            // The size marker must be exactly four bytes long and fit in
            // the record; anything else kills the rest of the record.
            if (type_acc == MARKER_TYPE) begin
                if (short_size != EXT_SIZE || rec_left < EXT_BYTES) begin
                    prs_phase  = PH_IDLE;
                    r.kind     = KIND_BAD_EXT;
                    r.sub_size = {11'd0, short_size};
                    return 1'b1;
                end
                long_size = '0;
                prs_phase = PH_EXT;
                return 1'b0;
            end

            // A nonzero extended size replaces the 16-bit one, once.
            sub       = (long_size != '0) ? long_size : {16'd0, short_size};
            long_size = '0;
            if (sub > {5'd0, rec_left}) begin
                prs_phase  = PH_IDLE;
                r.kind     = KIND_OVERRUN;
                r.sub_size = (sub > SIZE_MAX) ? SIZE_MAX[26:0] : sub[26:0];
                return 1'b1;
            end
            sub_len  = sub[26:0];
            sub_left = sub[26:0];
            sub_pos  = '0;
            if (sub == '0) begin
                prs_phase = PH_HEADER;
            end else begin
                prs_phase = PH_DATA;
            end
            r.kind     = KIND_HEADER;
            r.sub_size = sub[26:0];
            return 1'b1;
        end

        if (prs_phase == PH_EXT) begin
            rec_left = rec_left - 27'd1;
            long_size[8*hdr_idx[1:0] +: 8] = b;
            if (hdr_idx < EXT_LAST_IDX) begin
                hdr_idx = hdr_idx + 3'd1;
            end else begin
                hdr_idx   = '0;
                prs_phase = PH_HEADER;
            end
            return 1'b0;
        end

        // Data phase: every word comes back out with its offset.
        rec_left      = rec_left - 27'd1;
        r.kind        = KIND_DATA;
        r.sub_type    = type_acc;
        r.sub_size    = sub_len;
        r.byte_offset = sub_pos;
        r.out_byte    = b;
        r.last_of_sub = (sub_left == 27'd1);
        sub_pos       = sub_pos + 26'd1;
        if (sub_left != '0) begin
            sub_left = sub_left - 27'd1;
        end
        if (sub_left == '0) begin
            hdr_idx   = '0;
            prs_phase = PH_HEADER;
        end
        return 1'b1;
    endfunction

    // Offers one word after a random gap and holds it until it is taken.
    // Valid is only lowered when a gap follows, so back-to-back words never
    // see valid dropped and raised in the same step.
    task automatic send_word(input logic [7:0] b, input logic st, input logic [26:0] len);
        int      gap;
        t_result r;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_record_start <= st;
        i_record_bytes <= len;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (deframe_byte(b, st, len, r)) begin
            deframed_q.insert(deframed_q.size(), r);
        end
        words_sent++;
    endtask

    task automatic add_header(input logic [31:0] typ, input logic [15:0] sz);
        for (int k = 0; k < 4; k++) begin
            rec_buf.insert(rec_buf.size(), typ[8*k +: 8]);
        end
        rec_buf.insert(rec_buf.size(), sz[7:0]);
        rec_buf.insert(rec_buf.size(), sz[15:8]);
    endtask

    // A well-formed size marker followed by its 32-bit size.
    task automatic add_ext(input logic [31:0] long_len);
        add_header(MARKER_TYPE, EXT_SIZE);
        for (int k = 0; k < 4; k++) begin
            rec_buf.insert(rec_buf.size(), long_len[8*k +: 8]);
        end
    endtask

    task automatic add_data(input int n);
        logic [31:0] v;
        repeat (n) begin
            v = $urandom();
            rec_buf.insert(rec_buf.size(), v[7:0]);
        end
    endtask

    // Sends count words of the built record, the first one carrying the
    // record start and len. Words past the buffer are random filler, and
    // record_bytes on the other words is random since the block ignores it.
    task automatic send_record(input logic [26:0] len, input int count);
        logic [31:0] noise;
        for (int k = 0; k < count; k++) begin
            noise = $urandom();
            send_word((k < rec_buf.size()) ? rec_buf[k] : noise[7:0], k == 0,
                      (k == 0) ? len : noise[31:5]);
        end
        rec_buf.delete();
    endtask

    // A stray word before any record, then an empty record.
    task automatic test_idle_words();
        send_word(8'hFF, 1'b0, 27'h7FF_FFFF);
        send_word(8'h00, 1'b1, 27'd0);
    endtask

    // A zero-length subrecord gives only its header; the three words after
    // it are too few for another header and vanish.
    task automatic test_zero_length_and_tail();
        add_header(32'hFFFF_FFFF, 16'h0000);
        add_data(3);
        send_record(27'd9, 9);
    endtask

    // The largest record length is clamped. A small extended size overrides
    // a 16-bit size of all ones; a huge one overruns and saturates the size.
    task automatic test_extended_size();
        add_ext(32'd2);
        add_header(32'h0000_0000, 16'hFFFF);
        rec_buf.insert(rec_buf.size(), 8'h00);
        rec_buf.insert(rec_buf.size(), 8'hFF);
        add_ext(32'hFFFF_FFFF);
        add_header(32'h1234_5678, 16'h0001);
        send_record(27'h7FF_FFFF, rec_buf.size());
    endtask

    // A record cut short by a new record start, whose header then claims
    // more data than the record holds.
    task automatic test_overrun_and_restart();
        add_header(32'h4142_4344, 16'd3);
        add_data(1);
        send_record(27'd100, 7);
        add_header(32'h4443_4241, 16'hFFFF);
        send_record(27'd6, 6);
    endtask

    // A marker of the wrong size, then a right-sized marker with no room
    // left for its extended size.
    task automatic test_bad_markers();
        add_header(MARKER_TYPE, 16'd5);
        send_record(27'd20, 6);
        add_header(MARKER_TYPE, EXT_SIZE);
        send_record(27'd8, 6);
    endtask

    // Mostly well-formed records with random content and pacing, mixed with
    // tails, short lengths, clamped lengths, cut records and stray words.
    task automatic test_random_records();
        int          goal, n_subs, pick, total, tail;
        logic [31:0] v, long_len, eff_len;
        logic [15:0] short_len;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            // On each side, about a quarter of records run with no gaps.
            pick        = $urandom_range(0, 3);
            in_gap_max  = (pick == 0) ? 0 : $urandom_range(0, GAP_MAX);
            pick        = $urandom_range(0, 3);
            out_gap_max = (pick == 0) ? 0 : $urandom_range(0, GAP_MAX);

            n_subs = $urandom_range(1, 4);
            repeat (n_subs) begin
                pick     = $urandom_range(0, 99);
                long_len = '0;
                v        = $urandom();
                if (pick < 14) begin
                    case ($urandom_range(0, 3))
                        0:       long_len = '0;
                        1:       long_len = v;
                        default: long_len = {27'd0, v[4:0]};
                    endcase
                    add_ext(long_len);
                end else if (pick < 18) begin
                    add_header(MARKER_TYPE, v[15:0]);
                end
                v = $urandom();
                if ($urandom_range(0, 15) == 0) begin
                    short_len = v[15:0];
                end else begin
                    short_len = {12'd0, v[19:16]};
                end
                v = $urandom();
                if (v == MARKER_TYPE) begin
                    v = ~v;
                end
                add_header(v, short_len);
                eff_len = (long_len != '0) ? long_len : {16'd0, short_len};
                add_data((eff_len <= 32'd40) ? int'(eff_len) : 3);
            end

            total = rec_buf.size();
            pick  = $urandom_range(0, 99);
            if (pick < 64) begin
                send_record(27'(total), total);
            end else if (pick < 77) begin
                tail = $urandom_range(1, 5);
                add_data(tail);
                send_record(27'(total + tail), total + tail);
            end else if (pick < 86) begin
                tail = $urandom_range(1, (total > 8) ? 8 : total - 1);
                send_record(27'(total - tail), total);
            end else if (pick < 93) begin
                v = $urandom();
                send_record(v[26:0], total);
            end else begin
                send_record(27'(total), $urandom_range(1, total));
            end

            // Occasional stray word or empty record between records.
            if ($urandom_range(0, 9) == 0) begin
                v = $urandom();
                send_word(v[7:0], v[8], v[8] ? 27'd0 : v[31:5]);
            end
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        end
    endtask

    // Output side: a random stall before each word, then hold ready until a
    // word is taken. Ready stays high across words when no stall is drawn.
    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, out_gap_max);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Every word taken from the output is checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (deframed_q.size() == 0) begin
                flag_mismatch("unexpected word, kind", 32'd0, {30'd0, o_kind});
            end else begin
                want = deframed_q.pop_front();
                if (o_kind !== want.kind)
                    flag_mismatch("kind", 32'(want.kind), 32'(o_kind));
                if (o_sub_type !== want.sub_type)
                    flag_mismatch("sub_type", want.sub_type, o_sub_type);
                if (o_sub_size !== want.sub_size)
                    flag_mismatch("sub_size", 32'(want.sub_size), 32'(o_sub_size));
                if (o_byte_offset !== want.byte_offset)
                    flag_mismatch("byte_offset", 32'(want.byte_offset),
                                  32'(o_byte_offset));
                if (o_out_byte !== want.out_byte)
                    flag_mismatch("out_byte", 32'(want.out_byte), 32'(o_out_byte));
                if (o_last_of_sub !== want.last_of_sub)
                    flag_mismatch("last_of_sub", 32'(want.last_of_sub),
                                  32'(o_last_of_sub));
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_data_byte    <= '0;
        i_record_start <= 1'b0;
        i_record_bytes <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed part runs with full-range gaps on both sides.
        in_gap_max  = GAP_MAX;
        out_gap_max = GAP_MAX;
        test_idle_words();
        test_zero_length_and_tail();
        test_extended_size();
        test_overrun_and_restart();
        test_bad_markers();
        test_random_records();

        // The last word was taken at this edge; drop valid before the next.
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
